// File: src/count_min_sketch_defines.svh
// assertion macros shared by the sketch rtl
`ifndef COUNT_MIN_SKETCH_DEFINES_SVH
`define COUNT_MIN_SKETCH_DEFINES_SVH

// antecedent holds, consequent in the same cycle
`define CMS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// antecedent holds, consequent in the next cycle
`define CMS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// condition never seen
`define CMS_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: src/cms_pkg.sv
`default_nettype none

package cms_pkg;

	localparam int HASH_W      = 64;
	localparam int CNT_W       = 32;
	localparam int MULT_W      = 10;
	localparam int ADD_W       = 20;
	localparam int REG_ROWS    = 4;
	localparam int CFG_IDX_W   = 4;
	localparam int CFG_DATA_W  = 20;
	localparam int DEF_ROWS    = 4;
	localparam int DEF_COLUMNS = 1024;
	localparam int FOLD_STEPS  = 4;
	localparam int MOD_STEPS   = FOLD_STEPS + 3;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	localparam logic [REG_ROWS-1:0][MULT_W-1:0] MULT_RESET = {10'd7, 10'd5, 10'd3, 10'd1};
	localparam logic [REG_ROWS-1:0][ADD_W-1:0]  ADD_RESET  = {20'd47, 20'd23, 20'd11, 20'd0};

	localparam logic REQ_UPDATE = 1'b0;
	localparam logic REQ_QUERY  = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MULT_0 = 4'd0,
		REG_MULT_1 = 4'd1,
		REG_MULT_2 = 4'd2,
		REG_MULT_3 = 4'd3,
		REG_ADD_0  = 4'd4,
		REG_ADD_1  = 4'd5,
		REG_ADD_2  = 4'd6,
		REG_ADD_3  = 4'd7
	} cfg_reg_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_MUL,
		F_ADD,
		F_MOD,
		F_PUSH
	} front_state_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_flags_t;

	typedef logic [REG_ROWS-1:0][MULT_W-1:0] mult_bank_t;
	typedef logic [REG_ROWS-1:0][ADD_W-1:0]  add_bank_t;

endpackage

`default_nettype wire

// File: src/cms_queue.sv
`default_nettype none

module cms_queue
	import cms_pkg::*;
#(
	parameter int WIDTH = 41
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] pop_data,
	output queue_flags_t          flags
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0]  ent_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_QW-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign flags.full  = (count_q == CNT_QW'(QUEUE_DEPTH));
	assign flags.empty = (count_q == '0);
	assign do_push     = push && !flags.full;
	assign do_pop      = pop && !flags.empty;
	assign pop_data    = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// File: src/cms_front.sv
`default_nettype none

module cms_front
	import cms_pkg::*;
#(
	parameter int ROWS    = DEF_ROWS,
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int COL_W   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         accept,
	input  wire logic                         req_type,
	input  wire logic [HASH_W-1:0]            key_hash,
	input  wire mult_bank_t                   row_mult,
	input  wire add_bank_t                    row_add,
	input  wire queue_flags_t                 flags,
	output logic                              push,
	output logic      [ROWS*COL_W:0]          entry,
	output logic                              idle
);

	`include "count_min_sketch_defines.svh"

	localparam bit COL_POW2 = (COLUMNS == (1 << COL_W));
	localparam int STEP_W = $clog2(MOD_STEPS);
	localparam int HALF_W = HASH_W / 2;

	// 2^32 mod columns folds the upper half back onto the lower half
	localparam logic [HASH_W-1:0] COL_64 = HASH_W'(COLUMNS);
	localparam logic [HASH_W-1:0] FOLD_R = (HASH_W'(1) << HALF_W) % COL_64;
	// reciprocal giving an exact quotient of a 32-bit value by columns
	localparam logic [HASH_W:0] RECIP_WIDE =
		((HASH_W + 1)'(1) << (HALF_W + COL_W)) / (HASH_W + 1)'(COLUMNS) + 1'b1;
	localparam logic [HALF_W:0] RECIP = RECIP_WIDE[HALF_W:0];

	localparam logic [STEP_W-1:0] STEP_RECIP = STEP_W'(FOLD_STEPS);
	localparam logic [STEP_W-1:0] STEP_BACK  = STEP_W'(FOLD_STEPS + 1);

	front_state_t state_q, state_d;

	logic              req_q;
	logic [HASH_W-1:0] hash_q;
	logic [HASH_W-1:0] prod_q  [ROWS];
	logic [HASH_W-1:0] mixed_q [ROWS];
	logic [COL_W-1:0]  rem_q   [ROWS];
	logic [HASH_W:0]   recip_prod [ROWS];
	logic [STEP_W-1:0] step_q;
	logic [ROWS*COL_W-1:0] col_vec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		push    = 1'b0;
		idle    = 1'b0;
		case (state_q)
			F_IDLE: begin
				idle = 1'b1;
				if (accept) begin
					state_d = F_MUL;
				end
			end
			F_MUL: begin
				state_d = F_ADD;
			end
			F_ADD: begin
				state_d = COL_POW2 ? F_PUSH : F_MOD;
			end
			F_MOD: begin
				if (step_q == STEP_W'(MOD_STEPS - 1)) begin
					state_d = F_PUSH;
				end
			end
			F_PUSH: begin
				if (!flags.full) begin
					push    = 1'b1;
					state_d = F_IDLE;
				end
			end
			default: begin
				state_d = F_IDLE;
			end
		endcase
	end

	// lower half of the folded mix times the reciprocal
	always_comb begin
		for (int r = 0; r < ROWS; r++) begin
			recip_prod[r] = (HASH_W + 1)'(mixed_q[r][HALF_W-1:0]) * (HASH_W + 1)'(RECIP);
		end
	end

	// remainder by columns: four folds bring the mix below 2^32, then
	// quotient by reciprocal, quotient times columns, subtract
	always_ff @(posedge clk) begin
		if (accept && (state_q == F_IDLE)) begin
			req_q  <= req_type;
			hash_q <= key_hash;
		end
		for (int r = 0; r < ROWS; r++) begin
			case (state_q)
				F_MUL: begin
					prod_q[r] <= hash_q * HASH_W'(row_mult[r]);
				end
				F_ADD: begin
					mixed_q[r] <= prod_q[r] + HASH_W'(row_add[r]);
				end
				F_MOD: begin
					if (step_q < STEP_RECIP) begin
						mixed_q[r] <= HASH_W'(mixed_q[r][HASH_W-1:HALF_W]) * FOLD_R
							+ HASH_W'(mixed_q[r][HALF_W-1:0]);
					end else if (step_q == STEP_RECIP) begin
						prod_q[r] <= HASH_W'(recip_prod[r] >> (HALF_W + COL_W));
					end else if (step_q == STEP_BACK) begin
						prod_q[r] <= HASH_W'(prod_q[r][HALF_W-1:0]) * COL_64;
					end else begin
						rem_q[r] <= COL_W'(mixed_q[r][HALF_W-1:0] - prod_q[r][HALF_W-1:0]);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (state_q == F_MOD) begin
			step_q <= step_q + 1'b1;
		end else begin
			step_q <= '0;
		end
	end

	always_comb begin
		for (int r = 0; r < ROWS; r++) begin
			col_vec[r*COL_W +: COL_W] = COL_POW2 ? mixed_q[r][COL_W-1:0] : rem_q[r];
		end
	end

	assign entry = {req_q, col_vec};

	`CMS_ASSERT_NXT(a_push_back_idle, clk, arst_n, (state_q == F_PUSH) && !flags.full, state_q == F_IDLE, "front did not return to idle after queue write")
	`CMS_ASSERT_IMP(a_mod_len, clk, arst_n, state_q == F_MOD, !COL_POW2, "reduction run for power of two columns")

endmodule

`default_nettype wire

// File: src/cms_back.sv
`default_nettype none

module cms_back
	import cms_pkg::*;
#(
	parameter int ROWS    = DEF_ROWS,
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int COL_W   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire queue_flags_t         flags,
	input  wire logic [ROWS*COL_W:0]  entry,
	output logic                      pop,
	output logic                      clearing,
	output logic                      done,
	output logic      [CNT_W-1:0]     frequency
);

	`include "count_min_sketch_defines.svh"

	logic                  clear_q;
	logic [COL_W-1:0]      clr_addr_q;
	logic                  rd_valid_s1;
	logic                  req_s1;
	logic [ROWS*COL_W-1:0] col_s1;
	logic [CNT_W-1:0]      rdata_s1 [ROWS];
	logic                  done_q;
	logic [CNT_W-1:0]      freq_q;
	logic                  we;
	logic [CNT_W-1:0]      best;

	// one read in flight at a time so a write lands before the next read
	assign pop      = !flags.empty && !clear_q && !rd_valid_s1;
	assign clearing = clear_q;
	assign we       = clear_q || (rd_valid_s1 && (req_s1 == REQ_UPDATE));

	for (genvar r = 0; r < ROWS; r++) begin : g_row
		logic [CNT_W-1:0] mem [COLUMNS];
		logic [COL_W-1:0] waddr;
		logic [CNT_W-1:0] wdata;

		assign waddr = clear_q ? clr_addr_q : col_s1[r*COL_W +: COL_W];
		assign wdata = clear_q ? '0 :
			((rdata_s1[r] == CNT_MAX) ? rdata_s1[r] : rdata_s1[r] + 1'b1);

		always_ff @(posedge clk) begin
			if (we) begin
				mem[waddr] <= wdata;
			end
			if (pop) begin
				rdata_s1[r] <= mem[entry[r*COL_W +: COL_W]];
			end
		end
	end

	always_comb begin
		best = CNT_MAX;
		for (int r = 0; r < ROWS; r++) begin
			if (rdata_s1[r] < best) begin
				best = rdata_s1[r];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_q     <= 1'b1;
			clr_addr_q  <= '0;
			rd_valid_s1 <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			if (clear_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == COL_W'(COLUMNS - 1)) begin
					clear_q <= 1'b0;
				end
			end
			rd_valid_s1 <= pop;
			done_q      <= rd_valid_s1 && (req_s1 == REQ_QUERY);
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			req_s1 <= entry[ROWS*COL_W];
			col_s1 <= entry[ROWS*COL_W-1:0];
		end
		if (rd_valid_s1) begin
			freq_q <= best;
		end
	end

	assign done      = done_q;
	assign frequency = freq_q;

	`CMS_ASSERT_NXT(a_query_done, clk, arst_n, rd_valid_s1 && (req_s1 == REQ_QUERY), done_q, "query read gave no result")
	`CMS_ASSERT_NEVER(a_clr_access, clk, arst_n, clear_q && rd_valid_s1, "table access during clearing pass")

endmodule

`default_nettype wire

// File: src/count_min_sketch.sv
`default_nettype none

// channel   | handshake            | payload
// ----------+----------------------+------------------------------------
// request   | start / busy         | req_type, key_hash
// result    | done (1-cycle strobe)| frequency
// config    | cfg_we               | cfg_index, cfg_data
//
// a word is taken on a rising edge with start high and busy low
// the front sequencer runs multiply, add, queue write and return to idle per word
//   when COLUMNS is a power of two; otherwise it runs extra steps that fold the
//   64-bit mix below 2^32 in four steps and take the remainder by COLUMNS with a
//   reciprocal multiply in three more
// the back end takes one word at a time (table read, then write or minimum);
//   done is registered from the table read of a query word
// after reset a clearing pass zeroes the table, busy held high
// the result strobe cannot be held off; a word of results is never stalled

module count_min_sketch
	import cms_pkg::*;
#(
	parameter int ROWS    = DEF_ROWS,
	parameter int COLUMNS = DEF_COLUMNS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// request channel
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic                  req_type,
	input  wire logic [HASH_W-1:0]     key_hash,
	// result channel
	output logic                       done,
	output logic      [CNT_W-1:0]      frequency,
	// configuration port
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	`include "count_min_sketch_defines.svh"

	localparam int COL_W   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam int ENTRY_W = ROWS * COL_W + 1;

	mult_bank_t         mult_q;
	add_bank_t          add_q;
	logic               accept;
	logic               front_idle;
	logic               clearing;
	logic               push;
	logic               pop;
	logic [ENTRY_W-1:0] push_data;
	logic [ENTRY_W-1:0] pop_data;
	queue_flags_t       flags;

	// new words wait for the clearing pass and for the front sequencer
	assign busy   = clearing || !front_idle;
	assign accept = start && !busy;

	// row coefficients; rows at or above ROWS are kept but never read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < REG_ROWS; r++) begin
				mult_q[r] <= MULT_RESET[r];
				add_q[r]  <= ADD_RESET[r];
			end
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_MULT_0: mult_q[0] <= cfg_data[MULT_W-1:0];
				REG_MULT_1: mult_q[1] <= cfg_data[MULT_W-1:0];
				REG_MULT_2: mult_q[2] <= cfg_data[MULT_W-1:0];
				REG_MULT_3: mult_q[3] <= cfg_data[MULT_W-1:0];
				REG_ADD_0:  add_q[0]  <= cfg_data[ADD_W-1:0];
				REG_ADD_1:  add_q[1]  <= cfg_data[ADD_W-1:0];
				REG_ADD_2:  add_q[2]  <= cfg_data[ADD_W-1:0];
				REG_ADD_3:  add_q[3]  <= cfg_data[ADD_W-1:0];
				default: begin
					// index beyond the register list: write dropped
				end
			endcase
		end
	end

	// front: takes the word and works out one column per row
	cms_front #(
		.ROWS    (ROWS),
		.COLUMNS (COLUMNS),
		.COL_W   (COL_W)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.req_type (req_type),
		.key_hash (key_hash),
		.row_mult (mult_q),
		.row_add  (add_q),
		.flags    (flags),
		.push     (push),
		.entry    (push_data),
		.idle     (front_idle)
	);

	// short queue of classified words between front and back
	cms_queue #(
		.WIDTH (ENTRY_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.flags     (flags)
	);

	// back: counter table per row, saturating update or minimum query
	cms_back #(
		.ROWS    (ROWS),
		.COLUMNS (COLUMNS),
		.COL_W   (COL_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.flags     (flags),
		.entry     (pop_data),
		.pop       (pop),
		.clearing  (clearing),
		.done      (done),
		.frequency (frequency)
	);

	`CMS_ASSERT_NEVER(a_push_full, clk, arst_n, push && flags.full, "queue written while full")
	`CMS_ASSERT_NXT(a_accept_busy, clk, arst_n, accept, busy, "busy not raised after a word was taken")

endmodule

`default_nettype wire
